// ===== rtl/topo_pkg.sv =====
// ----------------------------------------------------------------------------
// topo_pkg: shared types and constants for the topology reachability store
// Command codes, controller states and the control word broadcast to the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package topo_pkg;

    // node index width, fixed by the command fields
    localparam int NODE_IDX_W    = 6;
    // default node count
    localparam int MAX_NODES_DEF = 64;
    // width of the neighbor mask port
    localparam int MASK_W        = 64;

    // command codes
    typedef enum logic [2:0] {
        CMD_ADD    = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_PRUNE  = 3'd2,
        CMD_QNODE  = 3'd3,
        CMD_QEDGE  = 3'd4
    } t_cmd;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_EXEC,
        ST_PASS,
        ST_APPLY
    } t_state;

    // control word broadcast to every cell
    typedef struct packed {
        logic                  wr_en;
        logic                  wr_set;
        logic                  prune_en;
        logic [NODE_IDX_W-1:0] a;
        logic [NODE_IDX_W-1:0] b;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== rtl/topo_cell.sv =====
// ----------------------------------------------------------------------------
// topo_cell: one row of the adjacency matrix
// Holds the neighbor mask of one node, applies edge writes and the prune mask,
// and adds its share to the row-select, frontier and change chains.
// ----------------------------------------------------------------------------
`default_nettype none

module topo_cell #(
    parameter int N   = 64,
    parameter int IDX = 0
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire topo_pkg::t_cell_ctl i_ctl,
    input  wire logic [N-1:0]        i_reach,
    input  wire logic [N-1:0]        i_sel_chain,
    input  wire logic [N-1:0]        i_reach_chain,
    input  wire logic                i_chg_chain,
    output logic      [N-1:0]        o_sel_chain,
    output logic      [N-1:0]        o_reach_chain,
    output logic                     o_chg_chain
);
    import topo_pkg::*;

    logic [N-1:0] r_row;
    logic [N-1:0] n_row;
    logic [N-1:0] w_keep;
    logic         w_is_a;
    logic         w_is_b;

    assign w_is_a = (i_ctl.a == NODE_IDX_W'(IDX));
    assign w_is_b = (i_ctl.b == NODE_IDX_W'(IDX));
    // unreachable row loses everything, reachable row keeps reachable bits
    assign w_keep = i_reach[IDX] ? (r_row & i_reach) : '0;

    // next row value
    always_comb begin
        n_row = r_row;
        if (i_ctl.wr_en) begin
            if (w_is_a) begin
                if (i_ctl.wr_set) n_row = n_row | (N'(1) << i_ctl.b);
                else              n_row = n_row & ~(N'(1) << i_ctl.b);
            end
            if (w_is_b) begin
                if (i_ctl.wr_set) n_row = n_row | (N'(1) << i_ctl.a);
                else              n_row = n_row & ~(N'(1) << i_ctl.a);
            end
        end else if (i_ctl.prune_en) begin
            n_row = w_keep;
        end
    end

    // row register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
        end else begin
            r_row <= n_row;
        end
    end

    // chain contributions
    assign o_sel_chain   = i_sel_chain | (w_is_a ? r_row : '0);
    assign o_reach_chain = i_reach_chain | (i_reach[IDX] ? r_row : '0);
    assign o_chg_chain   = i_chg_chain | (w_keep != r_row);

endmodule

`default_nettype wire

// ===== rtl/topology_graph_reach_prune.sv =====
// ----------------------------------------------------------------------------
// topology_graph_reach_prune: adjacency-matrix topology store with pruning
// Edge add/remove, node and edge queries, and pruning of nodes unreachable
// from master node 0, over a row of cells that each hold one matrix row.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; exactly one result
// beat follows on o_valid and must be taken in that cycle, since the block
// cannot hold results. Add, remove and the two queries keep busy high through
// the row read and execute states, and the result beat appears in the cycle
// after execute, while busy is already low again. Prune keeps busy high for
// the frontier passes from node 0 and then the apply state: the cell chain
// widens the reachable set by one hop per cycle until it stops growing, and
// the apply state masks every row and collects the change flag.
// ----------------------------------------------------------------------------
`default_nettype none

module topology_graph_reach_prune #(
    parameter int MAX_NODES = topo_pkg::MAX_NODES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [2:0]                      i_cmd,
    input  wire logic [topo_pkg::NODE_IDX_W-1:0] i_node_a,
    input  wire logic [topo_pkg::NODE_IDX_W-1:0] i_node_b,
    output logic                                 o_valid,
    output logic                                 o_ok,
    output logic [topo_pkg::MASK_W-1:0]          o_neighbors,
    output logic                                 o_node_present,
    output logic                                 o_maybe_disconnected
);
    import topo_pkg::*;

    localparam int N = MAX_NODES;

    t_state                r_state, n_state;
    t_cmd                  r_cmd;
    logic [NODE_IDX_W-1:0] r_a;
    logic [NODE_IDX_W-1:0] r_b;
    logic [N-1:0]          r_row;
    logic [N-1:0]          r_reach, n_reach;
    logic                  r_flag, n_flag;
    logic                  r_valid, n_valid;
    logic                  r_ok, n_ok;
    logic [MASK_W-1:0]     r_nbrs, n_nbrs;
    logic                  r_present, n_present;
    logic                  r_out_flag, n_out_flag;

    t_cell_ctl             w_ctl;
    logic [N-1:0]          w_sel   [0:N];
    logic [N-1:0]          w_rch   [0:N];
    logic                  w_chg   [0:N];
    logic [N-1:0]          w_next_reach;
    logic                  w_a_ok;
    logic                  w_b_ok;
    logic                  w_edge;

    // cell chain
    assign w_sel[0] = '0;
    assign w_rch[0] = '0;
    assign w_chg[0] = 1'b0;

    for (genvar g = 0; g < N; g++) begin : g_cell
        topo_cell #(
            .N   (N),
            .IDX (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_reach       (r_reach),
            .i_sel_chain   (w_sel[g]),
            .i_reach_chain (w_rch[g]),
            .i_chg_chain   (w_chg[g]),
            .o_sel_chain   (w_sel[g+1]),
            .o_reach_chain (w_rch[g+1]),
            .o_chg_chain   (w_chg[g+1])
        );
    end

    // decode helpers
    assign w_a_ok       = ({1'b0, r_a} < (NODE_IDX_W + 1)'(N));
    assign w_b_ok       = ({1'b0, r_b} < (NODE_IDX_W + 1)'(N));
    assign w_edge       = |(r_row & (N'(1) << r_b));
    assign w_next_reach = r_reach | w_rch[N];

    // next state and outputs
    always_comb begin
        n_state        = r_state;
        n_reach        = r_reach;
        n_flag         = r_flag;
        n_valid        = 1'b0;
        n_ok           = r_ok;
        n_nbrs         = r_nbrs;
        n_present      = r_present;
        n_out_flag     = r_out_flag;
        w_ctl.wr_en    = 1'b0;
        w_ctl.wr_set   = 1'b0;
        w_ctl.prune_en = 1'b0;
        w_ctl.a        = r_a;
        w_ctl.b        = r_b;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (t_cmd'(i_cmd) == CMD_PRUNE) begin
                        n_reach = N'(1);
                        n_state = ST_PASS;
                    end else begin
                        n_state = ST_LOOK;
                    end
                end
            end
            ST_LOOK: begin
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_ok      = 1'b0;
                n_nbrs    = '0;
                n_present = 1'b0;
                case (r_cmd)
                    CMD_ADD: begin
                        if (w_a_ok && w_b_ok && !w_edge) begin
                            w_ctl.wr_en  = 1'b1;
                            w_ctl.wr_set = 1'b1;
                            n_ok         = 1'b1;
                        end
                    end
                    CMD_REMOVE: begin
                        if (w_a_ok && w_b_ok && w_edge) begin
                            w_ctl.wr_en = 1'b1;
                            n_flag      = 1'b1;
                            n_ok        = 1'b1;
                        end
                    end
                    CMD_QNODE: begin
                        if (w_a_ok) begin
                            n_nbrs    = MASK_W'(r_row);
                            n_present = |r_row;
                        end
                    end
                    CMD_QEDGE: begin
                        n_ok = w_a_ok && w_b_ok && w_edge;
                    end
                    default: begin
                    end
                endcase
                n_out_flag = n_flag;
                n_valid    = 1'b1;
                n_state    = ST_IDLE;
            end
            ST_PASS: begin
                if (w_next_reach == r_reach) begin
                    n_state = ST_APPLY;
                end else begin
                    n_reach = w_next_reach;
                end
            end
            ST_APPLY: begin
                w_ctl.prune_en = 1'b1;
                n_flag         = 1'b0;
                n_ok           = w_chg[N];
                n_nbrs         = '0;
                n_present      = 1'b0;
                n_out_flag     = 1'b0;
                n_valid        = 1'b1;
                n_state        = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_flag  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_flag  <= n_flag;
            r_valid <= n_valid;
        end
    end

    // command latch, row capture and result payload
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && start) begin
            r_cmd <= t_cmd'(i_cmd);
            r_a   <= i_node_a;
            r_b   <= i_node_b;
        end
        if (r_state == ST_LOOK) begin
            r_row <= w_sel[N];
        end
        r_reach    <= n_reach;
        r_ok       <= n_ok;
        r_nbrs     <= n_nbrs;
        r_present  <= n_present;
        r_out_flag <= n_out_flag;
    end

    assign busy                 = (r_state != ST_IDLE);
    assign o_valid              = r_valid;
    assign o_ok                 = r_ok;
    assign o_neighbors          = r_nbrs;
    assign o_node_present       = r_present;
    assign o_maybe_disconnected = r_out_flag;

endmodule

`default_nettype wire
